@@ hw/rtl/swcs_pkg.sv @@
// Shared types, codes and constants of the sliding window congestion sender.
`timescale 1ns / 1ps

package swcs_pkg;

	localparam int SEQ_W     = 32;
	localparam int CNT_W     = 7;
	localparam int WIN_W     = 16;
	localparam int RETRY_W   = 5;
	localparam int OP_W      = 3;
	localparam int KIND_W    = 4;
	localparam int CFG_IDX_W = 1;
	localparam int BURST_W   = 5;

	localparam int DEFAULT_WINDOW_SLOTS = 16;
	localparam int MAX_BURST            = 16;

	localparam logic [WIN_W-1:0]   RST_ADV_WINDOW = WIN_W'(16);
	localparam logic [RETRY_W-1:0] RST_RETRIES    = RETRY_W'(12);

	localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
	localparam logic [OP_W-1:0] OP_ACK     = 3'd1;
	localparam logic [OP_W-1:0] OP_TIMEOUT = 3'd2;
	localparam logic [OP_W-1:0] OP_SEND    = 3'd3;
	localparam logic [OP_W-1:0] OP_INIT    = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_ADV_WINDOW = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRY  = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_QUEUED  = 4'd0,
		KIND_FULL    = 4'd1,
		KIND_OLD_ACK = 4'd2,
		KIND_ACK     = 4'd3,
		KIND_SEND    = 4'd4,
		KIND_FAST_RT = 4'd5,
		KIND_TIMEOUT = 4'd6,
		KIND_GAVE_UP = 4'd7,
		KIND_NOTHING = 4'd8
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HEAD,
		ST_PUSH,
		ST_DIFF,
		ST_DUP,
		ST_GROW,
		ST_AVOID,
		ST_ACK_UPD,
		ST_TIMEOUT,
		ST_SEND_CW,
		ST_SEND_ADV,
		ST_SEND,
		ST_FIN
	} state_t;

	typedef struct packed {
		kind_t              kind;
		logic [SEQ_W-1:0]   seq;
		logic [WIN_W-1:0]   cwnd;
		logic [WIN_W-1:0]   ssth;
		logic [CNT_W-1:0]   in_flight;
		logic               last;
	} res_t;

endpackage

@@ hw/rtl/swcs_alu.sv @@
// Shared 32-bit adder and subtractor with carry out, used by the sequencer.
`timescale 1ns / 1ps

module swcs_alu (
	input  logic [swcs_pkg::SEQ_W-1:0] a,
	input  logic [swcs_pkg::SEQ_W-1:0] b,
	input  logic                       sub,
	output logic [swcs_pkg::SEQ_W:0]   res
);
	import swcs_pkg::*;

	always_comb begin
		if (sub) begin
			res = {1'b0, a} - {1'b0, b};
		end else begin
			res = {1'b0, a} + {1'b0, b};
		end
	end

endmodule

@@ hw/rtl/swcs_core.sv @@
// Sequencer and sender state: walks each event through the shared arithmetic unit.
`timescale 1ns / 1ps

module swcs_core #(
	parameter int WINDOW_SLOTS = swcs_pkg::DEFAULT_WINDOW_SLOTS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [swcs_pkg::OP_W-1:0]    opcode,
	input  logic [swcs_pkg::SEQ_W-1:0]   ack_seq,
	input  logic [swcs_pkg::WIN_W-1:0]   peer_window,
	input  logic [swcs_pkg::WIN_W-1:0]   init_adv,
	input  logic [swcs_pkg::RETRY_W-1:0] max_retries,
	output logic                         res_valid,
	input  logic                         res_take,
	output swcs_pkg::res_t               res
);
	import swcs_pkg::*;

	localparam logic [CNT_W-1:0]   SLOTS = CNT_W'(WINDOW_SLOTS);
	localparam logic [BURST_W-1:0] BURST = BURST_W'(MAX_BURST);

	function automatic logic [BURST_W-1:0] clamp_burst(input logic [WIN_W:0] v);
		if (v > (WIN_W + 1)'(MAX_BURST)) begin
			return BURST;
		end
		return v[BURST_W-1:0];
	endfunction

	state_t st_q, st_d;

	logic [SEQ_W-1:0]   next_seq_q;
	logic [CNT_W-1:0]   queued_q, sent_q, transit_q;
	logic [WIN_W-1:0]   cwnd_q, ssth_q, credit_q, adv_q;
	logic [1:0]         dupc_q;
	logic [SEQ_W-1:0]   dupm_q;
	logic [RETRY_W-1:0] retry_q;

	logic [OP_W-1:0]    op_q;
	logic [SEQ_W-1:0]   ack_q;
	logic [WIN_W-1:0]   peer_q;
	logic [SEQ_W-1:0]   head_q;
	logic [CNT_W-1:0]   d_q;
	logic [WIN_W:0]     sum_q;
	logic [BURST_W-1:0] cnt_q;
	kind_t              ekind_q;

	logic [SEQ_W-1:0] alu_a, alu_b;
	logic             alu_sub;
	logic [SEQ_W:0]   alu_res;

	logic               in_fire, res_fire;
	logic               full, old_ack, match, fast, avoid_mode;
	logic [CNT_W-1:0]   d_new, transit_inc, transit_less_d, thresh;
	logic [WIN_W-1:0]   cwnd_inc, half_cwnd;
	logic [CNT_W:0]     qt_diff;
	logic [CNT_W-1:0]   qs_diff, small_a, small_b;
	logic [BURST_W-1:0] small_lim, cw_lim, adv_lim, cnt_init, send_cnt;
	logic               give_up;

	swcs_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.res (alu_res)
	);

	assign in_fire  = in_valid && in_ready;
	assign res_fire = res_valid && res_take;

	assign full       = queued_q >= SLOTS;
	assign old_ack    = alu_res[SEQ_W-1];
	assign d_new      = ((|alu_res[SEQ_W-1:CNT_W]) || (alu_res[CNT_W-1:0] > queued_q)) ?
		queued_q : alu_res[CNT_W-1:0];
	assign match      = (alu_res[SEQ_W-1:0] == '0);
	assign fast       = match && (dupc_q == 2'd2);
	assign avoid_mode = cwnd_q >= ssth_q;
	assign transit_inc    = (transit_q == '1) ? transit_q : transit_q + 1'b1;
	assign transit_less_d = (transit_q > d_q) ? transit_q - d_q : '0;
	assign cwnd_inc       = (cwnd_q == '1) ? cwnd_q : cwnd_q + 1'b1;
	assign half_cwnd      = {1'b0, cwnd_q[WIN_W-1:1]};
	assign give_up        = ({1'b0, retry_q} + 1'b1) > {1'b0, max_retries};

	always_comb begin
		if (half_cwnd > {{(WIN_W - CNT_W){1'b0}}, SLOTS}) begin
			thresh = SLOTS;
		end else begin
			thresh = half_cwnd[CNT_W-1:0];
		end
		if (thresh < CNT_W'(2)) begin
			thresh = CNT_W'(2);
		end
	end

	// Send limits from the small counters and, for the window checks, from the shared adder's result.
	always_comb begin
		qt_diff = {1'b0, queued_q} - {1'b0, transit_q};
		qs_diff = queued_q - sent_q;
		small_a = (qs_diff < SLOTS) ? qs_diff : SLOTS;
		if (qt_diff[CNT_W]) begin
			small_b = '0;
		end else begin
			small_b = (qt_diff[CNT_W-1:0] < small_a) ? qt_diff[CNT_W-1:0] : small_a;
		end
		small_lim = clamp_burst({{(WIN_W + 1 - CNT_W){1'b0}}, small_b});
		cw_lim    = alu_res[SEQ_W] ? '0 : clamp_burst(alu_res[WIN_W:0]);
		adv_lim   = alu_res[SEQ_W] ? '0 : clamp_burst(alu_res[WIN_W:0]);
		cnt_init  = (cw_lim < small_lim) ? cw_lim : small_lim;
		send_cnt  = (adv_lim < cnt_q) ? adv_lim : cnt_q;
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (in_fire) st_d = ST_HEAD;
			end
			ST_HEAD: begin
				unique case (op_q)
					OP_PUSH:    st_d = full ? ST_FIN : ST_PUSH;
					OP_ACK:     st_d = ST_DIFF;
					OP_TIMEOUT: st_d = ST_TIMEOUT;
					OP_SEND:    st_d = ST_SEND_CW;
					default:    st_d = ST_FIN;
				endcase
			end
			ST_PUSH: begin
				if (res_fire) st_d = ST_IDLE;
			end
			ST_DIFF:     st_d = old_ack ? ST_FIN : ST_DUP;
			ST_DUP:      st_d = fast ? ST_FIN : ST_GROW;
			ST_GROW:     st_d = avoid_mode ? ST_AVOID : ST_ACK_UPD;
			ST_AVOID:    st_d = ST_ACK_UPD;
			ST_ACK_UPD:  st_d = ST_FIN;
			ST_TIMEOUT:  st_d = ST_FIN;
			ST_SEND_CW:  st_d = ST_SEND_ADV;
			ST_SEND_ADV: st_d = (send_cnt == '0) ? ST_FIN : ST_SEND;
			ST_SEND: begin
				if (res_fire && cnt_q == BURST_W'(1)) st_d = ST_IDLE;
			end
			ST_FIN: begin
				if (res_fire) st_d = ST_IDLE;
			end
			default:     st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (st_q == ST_IDLE);
		alu_a         = '0;
		alu_b         = '0;
		alu_sub       = 1'b1;
		res_valid     = 1'b0;
		res.kind      = ekind_q;
		res.seq       = alu_res[SEQ_W-1:0];
		res.cwnd      = cwnd_q;
		res.ssth      = ssth_q;
		res.in_flight = transit_q;
		res.last      = 1'b1;
		unique case (st_q)
			ST_HEAD, ST_FIN: begin
				alu_a = next_seq_q;
				alu_b = {{(SEQ_W - CNT_W){1'b0}}, queued_q};
				res_valid = (st_q == ST_FIN);
			end
			ST_PUSH: begin
				alu_a     = next_seq_q;
				alu_b     = SEQ_W'(1);
				alu_sub   = 1'b0;
				res_valid = 1'b1;
				res.kind  = KIND_QUEUED;
				res.seq   = next_seq_q;
			end
			ST_DIFF: begin
				alu_a = ack_q;
				alu_b = head_q;
			end
			ST_DUP: begin
				alu_a = ack_q;
				alu_b = dupm_q;
			end
			ST_GROW: begin
				alu_a   = {{(SEQ_W - WIN_W){1'b0}}, avoid_mode ? credit_q : cwnd_q};
				alu_b   = {{(SEQ_W - CNT_W){1'b0}}, d_q};
				alu_sub = 1'b0;
			end
			ST_AVOID: begin
				alu_a = {{(SEQ_W - WIN_W - 1){1'b0}}, sum_q};
				alu_b = {{(SEQ_W - WIN_W){1'b0}}, cwnd_q};
			end
			ST_SEND_CW: begin
				alu_a = {{(SEQ_W - WIN_W){1'b0}}, cwnd_q};
				alu_b = {{(SEQ_W - CNT_W){1'b0}}, transit_q};
			end
			ST_SEND_ADV: begin
				alu_a = {{(SEQ_W - WIN_W){1'b0}}, adv_q};
				alu_b = {{(SEQ_W - CNT_W){1'b0}}, transit_q};
			end
			ST_SEND: begin
				alu_a         = head_q;
				alu_b         = {{(SEQ_W - CNT_W){1'b0}}, sent_q};
				alu_sub       = 1'b0;
				res_valid     = 1'b1;
				res.kind      = KIND_SEND;
				res.in_flight = transit_inc;
				res.last      = (cnt_q == BURST_W'(1));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			next_seq_q <= '0;
			queued_q   <= '0;
			sent_q     <= '0;
			transit_q  <= '0;
			cwnd_q     <= WIN_W'(1);
			ssth_q     <= RST_ADV_WINDOW;
			credit_q   <= '0;
			dupc_q     <= '0;
			dupm_q     <= '0;
			adv_q      <= RST_ADV_WINDOW;
			retry_q    <= '0;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				ST_HEAD: begin
					if (op_q == OP_INIT) begin
						next_seq_q <= '0;
						queued_q   <= '0;
						sent_q     <= '0;
						transit_q  <= '0;
						cwnd_q     <= WIN_W'(1);
						ssth_q     <= init_adv;
						credit_q   <= '0;
						dupc_q     <= '0;
						dupm_q     <= '0;
						adv_q      <= init_adv;
						retry_q    <= '0;
					end
				end
				ST_PUSH: begin
					if (res_fire) begin
						next_seq_q <= alu_res[SEQ_W-1:0];
						queued_q   <= queued_q + 1'b1;
					end
				end
				ST_DUP: begin
					if (match) begin
						if (fast) begin
							dupc_q <= '0;
							if (cwnd_q > ssth_q) begin
								cwnd_q <= (ssth_q == '0) ? WIN_W'(1) : ssth_q;
							end
						end else begin
							dupc_q <= dupc_q + 1'b1;
						end
					end else begin
						transit_q <= transit_less_d;
						dupc_q    <= '0;
						dupm_q    <= ack_q;
					end
				end
				ST_GROW: begin
					if (!avoid_mode) begin
						cwnd_q   <= (alu_res[WIN_W:0] > {1'b0, ssth_q}) ?
							ssth_q : alu_res[WIN_W-1:0];
						credit_q <= '0;
					end
				end
				ST_AVOID: begin
					if (!alu_res[SEQ_W]) begin
						cwnd_q   <= cwnd_inc;
						credit_q <= alu_res[WIN_W] ? '1 : alu_res[WIN_W-1:0];
					end else begin
						credit_q <= sum_q[WIN_W] ? '1 : sum_q[WIN_W-1:0];
					end
				end
				ST_ACK_UPD: begin
					adv_q    <= peer_q;
					queued_q <= queued_q - d_q;
					sent_q   <= (sent_q > d_q) ? sent_q - d_q : '0;
					retry_q  <= '0;
				end
				ST_TIMEOUT: begin
					if (give_up) begin
						retry_q <= '0;
					end else begin
						retry_q   <= retry_q + 1'b1;
						transit_q <= '0;
						sent_q    <= '0;
						if (adv_q == '0) begin
							adv_q <= WIN_W'(1);
						end else begin
							ssth_q   <= {{(WIN_W - CNT_W){1'b0}}, thresh};
							credit_q <= '0;
							cwnd_q   <= WIN_W'(1);
						end
					end
				end
				ST_SEND: begin
					if (res_fire) begin
						sent_q    <= sent_q + 1'b1;
						transit_q <= transit_inc;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q   <= opcode;
			ack_q  <= ack_seq;
			peer_q <= peer_window;
		end
		unique case (st_q)
			ST_HEAD: begin
				head_q  <= alu_res[SEQ_W-1:0];
				ekind_q <= (op_q == OP_PUSH) ? KIND_FULL : KIND_NOTHING;
			end
			ST_DIFF: begin
				d_q     <= d_new;
				ekind_q <= KIND_OLD_ACK;
			end
			ST_DUP: begin
				ekind_q <= fast ? KIND_FAST_RT : KIND_ACK;
			end
			ST_GROW: begin
				sum_q <= alu_res[WIN_W:0];
			end
			ST_TIMEOUT: begin
				ekind_q <= give_up ? KIND_GAVE_UP : KIND_TIMEOUT;
			end
			ST_SEND_CW: begin
				cnt_q <= cnt_init;
			end
			ST_SEND_ADV: begin
				cnt_q   <= send_cnt;
				ekind_q <= KIND_NOTHING;
			end
			ST_SEND: begin
				if (res_fire) cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	a_sent_le_queued: assert property (@(posedge clk) disable iff (!arst_n)
		sent_q <= queued_q)
		else $error("More segments sent than queued.");

	a_cwnd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cwnd_q != '0)
		else $error("Congestion window dropped to zero.");

	a_send_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SEND) |-> (cnt_q != '0))
		else $error("Send burst running with an empty count.");

	a_one_word_per_push: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_PUSH && res_fire) |=> (st_q == ST_IDLE && queued_q != '0))
		else $error("Push did not complete with an entry queued.");

	a_dup_count: assert property (@(posedge clk) disable iff (!arst_n)
		dupc_q != 2'd3)
		else $error("Duplicate ack count passed the fast retransmit point.");

endmodule

@@ hw/rtl/sliding_window_congestion_sender_unit.sv @@
// A push, init, timeout, ack or other event gives one word; a send pass gives its segments,
// one per cycle while the output is not stalled, or one word when there is none to send.
// One event at a time; the next is taken once the last word of the current one
// has entered the output register.
// Reset clears the sender state to its idle values and restores the configuration
// registers to an advertised window of 16 and a retry limit of 12.
`timescale 1ns / 1ps

module sliding_window_congestion_sender_unit #(
	parameter int WINDOW_SLOTS = swcs_pkg::DEFAULT_WINDOW_SLOTS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [swcs_pkg::OP_W-1:0]      opcode,
	input  logic [swcs_pkg::SEQ_W-1:0]     ack_seq,
	input  logic [swcs_pkg::WIN_W-1:0]     peer_window,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [swcs_pkg::KIND_W-1:0]    kind,
	output logic [swcs_pkg::SEQ_W-1:0]     seq,
	output logic [swcs_pkg::WIN_W-1:0]     cwnd_now,
	output logic [swcs_pkg::WIN_W-1:0]     ssthresh_now,
	output logic [swcs_pkg::CNT_W-1:0]     in_flight,
	output logic                           last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [swcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [swcs_pkg::WIN_W-1:0]     cfg_data
);
	import swcs_pkg::*;

	logic [WIN_W-1:0]   init_adv_q;
	logic [RETRY_W-1:0] max_retry_q;
	logic               in_ready;
	logic               res_valid, res_take;
	res_t               res, res_q;
	logic               out_valid_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = !in_ready;
	assign res_take  = !out_valid_q || !out_stall;

	swcs_core #(
		.WINDOW_SLOTS (WINDOW_SLOTS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.ack_seq     (ack_seq),
		.peer_window (peer_window),
		.init_adv    (init_adv_q),
		.max_retries (max_retry_q),
		.res_valid   (res_valid),
		.res_take    (res_take),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_adv_q  <= RST_ADV_WINDOW;
			max_retry_q <= RST_RETRIES;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_ADV_WINDOW: init_adv_q  <= cfg_data;
					CFG_MAX_RETRY:  max_retry_q <= cfg_data[RETRY_W-1:0];
					default: begin
					end
				endcase
			end
			if (res_valid && res_take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = res_q.kind;
	assign seq          = res_q.seq;
	assign cwnd_now     = res_q.cwnd;
	assign ssthresh_now = res_q.ssth;
	assign in_flight    = res_q.in_flight;
	assign last         = res_q.last;

endmodule
